/* sv/swlps_pkg.sv */
// Shared types and constants for the single-wire LED pixel serializer.
// No dependencies; imported by the store and the top level.
package swlps_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 64;
  localparam int unsigned WORD_BITS      = 12;
  localparam int unsigned ROW_W          = 3 * WORD_BITS;
  localparam int unsigned STORE_AW       = 8;

  localparam logic [WORD_BITS-1:0] HEADER_WORD = 12'h3AA;
  localparam logic [3:0]           GAP_CELLS   = 4'd5;
  localparam logic [3:0]           LATCH_CELLS = 4'd8;

  localparam logic [1:0] REG_PIXEL_COUNT = 2'd0;
  localparam logic [1:0] REG_BIT_PERIOD  = 2'd1;
  localparam logic [1:0] REG_PULSE       = 2'd2;
  localparam logic [1:0] REG_OFFSET      = 2'd3;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_VALUE = 2'd2,
    STAT_BUSY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_DATA  = 2'd0,
    PH_GAP   = 2'd1,
    PH_LATCH = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } ctl_state_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  first_pixel;
    logic [7:0]  last_pixel;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } in_word_t;

  typedef struct packed {
    logic    line_level;
    logic    busy_res;
    status_e status;
  } out_word_t;

  typedef struct packed {
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [ROW_W-1:0]    wr_row;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic                clear;
  } store_req_t;

endpackage

/* sv/single_wire_led_pixel_serializer.sv */
// Single-wire LED pixel serializer, top level: register port, command
// control, range fill and line sequencer. Depends on swlps_pkg, swlps_store.
// Latency: a result is on res_o, marked by done_o, the cycle after its word
// is taken; ticks, clears and rejected commands take one word per cycle.
// A valid set range holds busy_o while its pixels are written (store write
// port), and its result follows the last write. The receiver cannot stall.
// Reset: registers to defaults, line idle, store rows read as zero at once.
module single_wire_led_pixel_serializer import swlps_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  in_word_t    cmd_i,
  output logic        busy_o,
  output logic        done_o,
  output out_word_t   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CW    = (CNT_W > 8) ? CNT_W : 8;

  logic [6:0] pixel_count_q;
  logic [7:0] bit_period_q;
  logic [5:0] pulse_q;
  logic [7:0] offset_q;

  ctl_state_e       state_q, state_d;
  logic [AW-1:0]    cur_q, cur_d, last_q, last_d;
  logic [ROW_W-1:0] fill_row_q, fill_row_d;

  logic                 sending_q, sending_d;
  phase_e               phase_q, phase_d;
  logic [AW-1:0]        pix_q, pix_d;
  logic [1:0]           word_q, word_d;
  logic [3:0]           bit_q, bit_d;
  logic [7:0]           tick_q, tick_d;
  logic [3:0]           idle_q, idle_d;
  logic [WORD_BITS-1:0] shift_q, shift_d;

  logic      done_q, done_d;
  out_word_t res_q, res_d;

  store_req_t       req;
  logic [ROW_W-1:0] rd_row;
  logic             rd_valid;

  logic                 cfg_wr;
  logic [CW-1:0]        eff;
  logic                 level_now;
  logic                 start_level;
  logic                 accept;
  logic                 range_bad;
  logic                 value_bad;
  logic                 do_advance;
  logic                 do_start;
  logic [8:0]           tick_inc;
  logic [8:0]           win_end;
  logic [3:0]           idle_dec;
  logic [WORD_BITS-1:0] next_word;

  swlps_store #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_row_o  (rd_row),
    .rd_valid_o(rd_valid)
  );

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_PIXEL_COUNT: prdata = 32'(pixel_count_q);
      REG_BIT_PERIOD:  prdata = 32'(bit_period_q);
      REG_PULSE:       prdata = 32'(pulse_q);
      REG_OFFSET:      prdata = 32'(offset_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= 7'd1;
      bit_period_q  <= 8'd16;
      pulse_q       <= 6'd2;
      offset_q      <= 8'd6;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PIXEL_COUNT: pixel_count_q <= pwdata[6:0];
        REG_BIT_PERIOD:  bit_period_q  <= pwdata[7:0];
        REG_PULSE:       pulse_q       <= pwdata[5:0];
        REG_OFFSET:      offset_q      <= pwdata[7:0];
        default:         ;
      endcase
    end
  end

  assign eff = (CW'(pixel_count_q) > CW'(MAX_PIXELS)) ? CW'(MAX_PIXELS)
                                                       : CW'(pixel_count_q);

  assign win_end   = {1'b0, offset_q} + 9'(pulse_q);
  assign level_now = sending_q && (phase_q == PH_DATA) &&
                     ((tick_q < 8'(pulse_q)) ||
                      (shift_q[WORD_BITS-1] && (tick_q >= offset_q) &&
                       (9'(tick_q) < win_end)));
  assign start_level = (eff != '0) && (pulse_q != '0);

  assign accept    = start_i && (state_q == ST_IDLE);
  assign range_bad = (CW'(cmd_i.first_pixel) >= eff) || (CW'(cmd_i.last_pixel) >= eff);
  assign value_bad = (cmd_i.red[15:12] != '0) || (cmd_i.green[15:12] != '0) ||
                     (cmd_i.blue[15:12] != '0);

  assign tick_inc = 9'(tick_q) + 9'd1;
  assign idle_dec = (idle_q != '0) ? idle_q - 4'd1 : 4'd0;

  always_comb begin
    case (word_q)
      2'd0:    next_word = rd_row[WORD_BITS-1:0];
      2'd1:    next_word = rd_row[2*WORD_BITS-1:WORD_BITS];
      default: next_word = rd_row[3*WORD_BITS-1:2*WORD_BITS];
    endcase
    if (!rd_valid) begin
      next_word = '0;
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    last_d     = last_q;
    fill_row_d = fill_row_q;
    sending_d  = sending_q;
    phase_d    = phase_q;
    pix_d      = pix_q;
    word_d     = word_q;
    bit_d      = bit_q;
    tick_d     = tick_q;
    idle_d     = idle_q;
    shift_d    = shift_q;
    done_d     = 1'b0;
    res_d      = res_q;
    req        = '0;
    do_advance = 1'b0;
    do_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          done_d           = 1'b1;
          res_d.line_level = level_now;
          res_d.busy_res   = sending_q;
          res_d.status     = STAT_OK;
          case (cmd_i.command)
            CMD_TICK: begin
              do_advance = sending_q;
            end
            CMD_SET: begin
              if (sending_q) begin
                res_d.status = STAT_BUSY;
              end else if (range_bad) begin
                res_d.status = STAT_RANGE;
              end else if (value_bad) begin
                res_d.status = STAT_VALUE;
              end else if (cmd_i.first_pixel > cmd_i.last_pixel) begin
                do_start = 1'b1;
              end else begin
                done_d     = 1'b0;
                state_d    = ST_FILL;
                cur_d      = AW'(cmd_i.first_pixel);
                last_d     = AW'(cmd_i.last_pixel);
                fill_row_d = {cmd_i.red[WORD_BITS-1:0], cmd_i.green[WORD_BITS-1:0],
                              cmd_i.blue[WORD_BITS-1:0]};
              end
            end
            CMD_CLEAR: begin
              if (sending_q) begin
                res_d.status = STAT_BUSY;
              end else begin
                req.clear = 1'b1;
                do_start  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        req.wr_en   = 1'b1;
        req.wr_addr = STORE_AW'(cur_q);
        req.wr_row  = fill_row_q;
        if (cur_q == last_q) begin
          state_d      = ST_IDLE;
          done_d       = 1'b1;
          res_d.status = STAT_OK;
          do_start     = 1'b1;
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_advance) begin
      if (tick_inc >= 9'(bit_period_q)) begin
        tick_d = '0;
        case (phase_q)
          PH_DATA: begin
            shift_d = {shift_q[WORD_BITS-2:0], 1'b0};
            if (bit_q == 4'(WORD_BITS - 1)) begin
              bit_d = '0;
              if (word_q == 2'd3) begin
                word_d  = '0;
                phase_d = PH_GAP;
                idle_d  = GAP_CELLS;
              end else begin
                word_d  = word_q + 2'd1;
                shift_d = next_word;
              end
            end else begin
              bit_d = bit_q + 4'd1;
            end
          end
          PH_GAP: begin
            idle_d = idle_dec;
            if (idle_dec == '0) begin
              if (CW'(pix_q) + CW'(1) >= eff) begin
                phase_d = PH_LATCH;
                idle_d  = LATCH_CELLS;
              end else begin
                pix_d       = pix_q + AW'(1);
                phase_d     = PH_DATA;
                word_d      = '0;
                bit_d       = '0;
                shift_d     = HEADER_WORD;
                req.rd_en   = 1'b1;
                req.rd_addr = STORE_AW'(pix_q + AW'(1));
              end
            end
          end
          PH_LATCH: begin
            idle_d = idle_dec;
            if (idle_dec == '0) begin
              sending_d = 1'b0;
              phase_d   = PH_DATA;
              pix_d     = '0;
              word_d    = '0;
              bit_d     = '0;
              shift_d   = '0;
            end
          end
          default: ;
        endcase
      end else begin
        tick_d = tick_inc[7:0];
      end
    end

    if (do_start) begin
      sending_d        = 1'b1;
      pix_d            = '0;
      tick_d           = '0;
      res_d.busy_res   = 1'b1;
      res_d.line_level = start_level;
      if (eff == '0) begin
        phase_d = PH_LATCH;
        idle_d  = LATCH_CELLS;
      end else begin
        phase_d     = PH_DATA;
        word_d      = '0;
        bit_d       = '0;
        shift_d     = HEADER_WORD;
        req.rd_en   = 1'b1;
        req.rd_addr = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sending_q <= 1'b0;
      phase_q   <= PH_DATA;
      pix_q     <= '0;
      word_q    <= '0;
      bit_q     <= '0;
      tick_q    <= '0;
      idle_q    <= '0;
      shift_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      sending_q <= sending_d;
      phase_q   <= phase_d;
      pix_q     <= pix_d;
      word_q    <= word_d;
      bit_q     <= bit_d;
      tick_q    <= tick_d;
      idle_q    <= idle_d;
      shift_q   <= shift_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    last_q     <= last_d;
    fill_row_q <= fill_row_d;
    res_q      <= res_d;
  end

  assign busy_o = (state_q == ST_FILL);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* sv/swlps_store.sv */
// Pixel store: one row of blue, green and red words per pixel, with a row
// valid bit that reset and clear drop at once. Depends on swlps_pkg.
module swlps_store import swlps_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_req_t       req_i,
  output logic [ROW_W-1:0] rd_row_o,
  output logic             rd_valid_o
);

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic [ROW_W-1:0]      mem_q [MAX_PIXELS];
  logic [MAX_PIXELS-1:0] valid_q;
  logic [ROW_W-1:0]      rd_row_q;
  logic                  rd_valid_q;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic                  same;

  assign waddr = req_i.wr_addr[AW-1:0];
  assign raddr = req_i.rd_addr[AW-1:0];
  assign same  = req_i.wr_en && (waddr == raddr);

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[waddr] <= req_i.wr_row;
    end
    if (req_i.rd_en) begin
      rd_row_q <= same ? req_i.wr_row : mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[waddr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= req_i.clear ? 1'b0 : (same ? 1'b1 : valid_q[raddr]);
      end
    end
  end

  assign rd_row_o   = rd_row_q;
  assign rd_valid_o = rd_valid_q;

endmodule
